FILE: sv/sawpr_pkg.sv
`default_nettype none
package sawpr_pkg;

	localparam int unsigned PAYLOAD_BYTES_DEF = 1024;
	localparam int unsigned QUEUE_DEPTH_DEF   = 2;

	localparam logic [7:0]  RETRY_LIMIT_RST = 8'd100;
	localparam logic [7:0]  RETRY_MAX       = 8'hFF;
	localparam logic [9:0]  WORD_INDEX_MAX  = 10'd1023;

	localparam logic [15:0] LBL_NAME   = 16'd4;
	localparam logic [15:0] LBL_DATA   = 16'd5;
	localparam logic [15:0] LBL_ERROR  = 16'd6;
	localparam logic [15:0] LBL_FINISH = 16'd7;

	localparam logic [1:0] COPIES_ONE   = 2'd1;
	localparam logic [1:0] COPIES_THREE = 2'd3;

	typedef enum logic [1:0] {
		PH_NAME = 2'd0,
		PH_DATA = 2'd1,
		PH_FAIL = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		K_NAMEACK = 2'd0,
		K_DATAACK = 2'd1,
		K_ERROR   = 2'd2,
		K_FINISH  = 2'd3
	} reply_kind_t;

	// One closed packet or one timeout, as seen by the decision logic.
	typedef struct packed {
		logic        timeout;
		logic        good;
		logic        is_name;
		logic        is_data;
		logic        is_error;
		logic        is_finish;
		logic        seq;
		logic [10:0] length;
	} event_t;

	typedef struct packed {
		reply_kind_t kind;
		logic        seq;
		logic [1:0]  copies;
		logic        deliver;
		logic [10:0] length;
		phase_t      phase_after;
	} reply_t;

endpackage
`default_nettype wire

FILE: sv/sawpr_fifo.sv
`default_nettype none
module sawpr_fifo import sawpr_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF,
	parameter int unsigned WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] dout,
	output logic                  empty
);

	localparam int unsigned PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == COUNT_FULL);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_FULL)
		else $error("queue count above depth");

endmodule
`default_nettype wire

FILE: sv/sawpr_front.sv
`default_nettype none
module sawpr_front import sawpr_pkg::*; #(
	parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic        action,
	input  wire logic [15:0] word,
	input  wire logic        last,
	output logic             ev_push,
	output event_t           ev
);

	localparam logic [16:0] LEN_CAP = 17'(PAYLOAD_BYTES);

	logic [9:0]  word_index_q;
	logic [15:0] sum_q;
	logic [15:0] label_q;
	logic        seq_q;
	logic [15:0] length_q;

	logic [15:0] label_eff;
	logic        seq_eff;
	logic [15:0] length_eff;
	logic [16:0] length_sat;
	logic [16:0] sum_add;
	logic [15:0] sum_next;

	always_comb begin
		label_eff  = (word_index_q >= 10'd1) ? label_q : '0;
		seq_eff    = (word_index_q >= 10'd2) ? seq_q : 1'b0;
		length_eff = (word_index_q >= 10'd3) ? length_q : '0;
		length_sat = ({1'b0, length_eff} > LEN_CAP) ? LEN_CAP : {1'b0, length_eff};
		sum_add    = {1'b0, sum_q} + {1'b0, word};
		sum_next   = sum_add[16] ? sum_add[15:0] + 16'd1 : sum_add[15:0];
	end

	always_comb begin
		ev_push      = accept && (action || last);
		ev.timeout   = action;
		ev.good      = (word == ~sum_q);
		ev.is_name   = (label_eff == LBL_NAME);
		ev.is_data   = (label_eff == LBL_DATA);
		ev.is_error  = (label_eff == LBL_ERROR);
		ev.is_finish = (label_eff == LBL_FINISH);
		ev.seq       = seq_eff;
		ev.length    = length_sat[10:0];
	end

	always_ff @(posedge clk) begin
		if (accept && !action && !last) begin
			if (word_index_q == 10'd0) begin
				label_q <= word;
			end
			if (word_index_q == 10'd1) begin
				seq_q <= word[0];
			end
			if (word_index_q == 10'd2) begin
				length_q <= word;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_index_q <= '0;
			sum_q        <= '0;
		end else if (accept) begin
			if (action || last) begin
				word_index_q <= '0;
				sum_q        <= '0;
			end else begin
				sum_q <= sum_next;
				if (word_index_q < WORD_INDEX_MAX) begin
					word_index_q <= word_index_q + 10'd1;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/sawpr_back.sv
`default_nettype none
module sawpr_back import sawpr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] retry_limit,
	input  wire logic       ev_valid,
	input  wire event_t     ev,
	output logic            ev_pop,
	input  wire logic       rp_full,
	output logic            rp_push,
	output reply_t          rp
);

	phase_t     phase_q;
	phase_t     phase_d;
	logic       exp_q;
	logic       exp_d;
	logic [7:0] rc_q;
	logic [7:0] rc_d;
	logic       limit_hit;
	logic [7:0] rc_bump;

	assign limit_hit = (rc_q >= retry_limit);
	assign rc_bump   = (rc_q == RETRY_MAX) ? rc_q : rc_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NAME;
			exp_q   <= 1'b0;
			rc_q    <= '0;
		end else begin
			phase_q <= phase_d;
			exp_q   <= exp_d;
			rc_q    <= rc_d;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		exp_d      = exp_q;
		rc_d       = rc_q;
		ev_pop     = ev_valid && !rp_full;
		rp_push    = 1'b0;
		rp.kind    = K_DATAACK;
		rp.seq     = exp_q;
		rp.copies  = COPIES_ONE;
		rp.deliver = 1'b0;
		rp.length  = '0;
		if (ev_pop) begin
			unique case (phase_q)
				PH_NAME: begin
					if (!ev.timeout && ev.good && ev.is_name) begin
						phase_d = PH_DATA;
						exp_d   = 1'b0;
						rc_d    = '0;
						rp_push = 1'b1;
						rp.kind = K_NAMEACK;
						rp.seq  = 1'b0;
					end else if (limit_hit || (!ev.timeout && ev.is_error)) begin
						phase_d   = PH_FAIL;
						rp_push   = 1'b1;
						rp.kind   = K_ERROR;
						rp.copies = COPIES_THREE;
					end else begin
						rc_d = rc_bump;
					end
				end
				PH_DATA: begin
					if (limit_hit || (!ev.timeout && ev.is_error)) begin
						phase_d   = PH_FAIL;
						rp_push   = 1'b1;
						rp.kind   = K_ERROR;
						rp.copies = COPIES_THREE;
					end else if (ev.timeout) begin
						rc_d    = rc_bump;
						rp_push = 1'b1;
					end else if (ev.is_finish) begin
						phase_d   = PH_NAME;
						rc_d      = '0;
						exp_d     = 1'b0;
						rp_push   = 1'b1;
						rp.kind   = K_FINISH;
						rp.copies = COPIES_THREE;
					end else if (!ev.good || (ev.seq != exp_q)) begin
						rc_d    = rc_bump;
						rp_push = 1'b1;
					end else if (ev.is_data) begin
						exp_d      = ~exp_q;
						rp_push    = 1'b1;
						rp.deliver = 1'b1;
						rp.length  = ev.length;
					end
				end
				default: begin
				end
			endcase
		end
		rp.phase_after = phase_d;
	end

	a_fail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FAIL |=> phase_q == PH_FAIL)
		else $error("left the failed phase without reset");

	a_error_copies: assert property (@(posedge clk) disable iff (!arst_n)
		rp_push && (rp.kind == K_ERROR || rp.kind == K_FINISH) |-> rp.copies == COPIES_THREE)
		else $error("error or finish reply without three copies");

	a_deliver_ack: assert property (@(posedge clk) disable iff (!arst_n)
		rp_push && rp.deliver |-> rp.kind == K_DATAACK && phase_d == PH_DATA)
		else $error("delivery outside a data ack");

endmodule
`default_nettype wire

FILE: sv/stop_and_wait_packet_receiver.sv
`default_nettype none
// Channel  Handshake          Beat
// input    push / full        action, word, last
// result   empty / pop        reply_kind, reply_seq, reply_copies, deliver,
//                             deliver_length, phase_after
// config   cfg_we             cfg_wdata (retry_limit)
//
// One word beat is accepted per cycle while full is low; the front updates the checksum
// and header capture in that cycle and closes a packet or a timeout into the event queue.
// The decision logic retires one event per cycle while the result queue is not full,
// and a reply passes from the event queue through the decision logic into the result
// queue before it reaches the result ports. full rises only when the event queue is
// full, which happens only while a full result queue holds back the decision logic.
// Reset is asynchronous and returns the block to the name phase with retry_limit 100.
module stop_and_wait_packet_receiver import sawpr_pkg::*; #(
	parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
	parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        action,
	input  wire logic [15:0] word,
	input  wire logic        last,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       reply_kind,
	output logic             reply_seq,
	output logic [1:0]       reply_copies,
	output logic             deliver,
	output logic [10:0]      deliver_length,
	output logic [1:0]       phase_after,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata
);

	logic [7:0] retry_limit_q;
	logic       accept;
	logic       ev_push;
	event_t     ev_in;
	event_t     ev_out;
	logic       ev_empty;
	logic       ev_pop;
	logic       rp_push;
	logic       rp_full;
	reply_t     rp_in;
	reply_t     rp_out;

	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= RETRY_LIMIT_RST;
		end else if (cfg_we) begin
			retry_limit_q <= cfg_wdata;
		end
	end

	sawpr_front #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.action (action),
		.word   (word),
		.last   (last),
		.ev_push(ev_push),
		.ev     (ev_in)
	);

	sawpr_fifo #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH($bits(event_t))
	) u_ev_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (ev_push),
		.din   (ev_in),
		.full  (full),
		.pop   (ev_pop),
		.dout  (ev_out),
		.empty (ev_empty)
	);

	sawpr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.retry_limit(retry_limit_q),
		.ev_valid   (!ev_empty),
		.ev         (ev_out),
		.ev_pop     (ev_pop),
		.rp_full    (rp_full),
		.rp_push    (rp_push),
		.rp         (rp_in)
	);

	sawpr_fifo #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH($bits(reply_t))
	) u_rp_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (rp_push),
		.din   (rp_in),
		.full  (rp_full),
		.pop   (pop),
		.dout  (rp_out),
		.empty (empty)
	);

	assign reply_kind     = rp_out.kind;
	assign reply_seq      = rp_out.seq;
	assign reply_copies   = rp_out.copies;
	assign deliver        = rp_out.deliver;
	assign deliver_length = rp_out.length;
	assign phase_after    = rp_out.phase_after;

endmodule
`default_nettype wire
